// File: hw/rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the sprite screen projection pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int FracBitsDefault = 16;
  localparam int DimW  = 13;                 // screen width / height
  localparam int RemW  = 84;                 // divider dividend and divisor width
  localparam int QcW   = 17;                 // column quotient, top bit is overflow
  localparam int QsW   = 16;                 // size quotient, top bit is overflow
  localparam int DivSteps = 17;
  localparam logic [DimW-1:0] DimMin = 13'd1;
  localparam logic [DimW-1:0] DimMax = 13'd4096;
  localparam logic [DimW-1:0] WidthReset  = 13'd640;
  localparam logic [DimW-1:0] HeightReset = 13'd480;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SINGULAR = 2'd1,
    STATUS_NO_DEPTH = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    REG_SCREEN_WIDTH  = 8'd0,
    REG_SCREEN_HEIGHT = 8'd1
  } reg_index_t;

  typedef struct packed {
    logic            valid;
    logic [7:0]      tag;
    status_t         status;
    logic            neg_c;
    logic [RemW-1:0] rem_c;
    logic [RemW-1:0] rem_s;
    logic [RemW-1:0] dv;
    logic [QcW-1:0]  qc;
    logic [QsW-1:0]  qs;
  } ssp_div_t;

endpackage

// File: hw/rtl/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front
// Offset, camera-space products, differences and scaling; ends in magnitudes
// ready for the divider chain. Five register stages.
// ----------------------------------------------------------------------------
module ssp_front #(
  parameter int FRAC_BITS = ssp_pkg::FracBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_tag,
  input  logic signed [31:0]  sprite_x,
  input  logic signed [31:0]  sprite_y,
  input  logic signed [31:0]  player_x,
  input  logic signed [31:0]  player_y,
  input  logic signed [31:0]  dir_x,
  input  logic signed [31:0]  dir_y,
  input  logic signed [31:0]  plane_x,
  input  logic signed [31:0]  plane_y,
  input  logic [11:0]         half_w,
  input  logic [12:0]         scr_h,
  output ssp_pkg::ssp_div_t   dout
);

  localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

  // stage 1: offsets
  logic [3:0] vld;
  logic [7:0] tag1, tag2, tag3, tag4;
  logic signed [33:0] sx1, sy1;
  logic signed [31:0] dx1, dy1, plx1, ply1;
  // stage 2: products
  logic signed [63:0] pd1, pd2;
  logic signed [65:0] pn1, pn2, py1, py2;
  // stage 3: differences
  logic signed [64:0] det3;
  logic signed [66:0] nx3, ny3;
  // stage 4: scaled numerators
  logic signed [79:0] numc4;
  logic signed [77:0] nums4;
  logic signed [66:0] ny4;
  logic det_zero4, ny_zero4;

  logic signed [67:0] sum3;
  logic signed [83:0] numc_x, nums_x, ny_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= in_tag;
    sx1  <= 34'(sprite_x) - 34'(player_x) + HALF;
    sy1  <= 34'(sprite_y) - 34'(player_y) + HALF;
    dx1  <= dir_x;
    dy1  <= dir_y;
    plx1 <= plane_x;
    ply1 <= plane_y;

    tag2 <= tag1;
    pd1  <= 64'(plx1) * 64'(dy1);
    pd2  <= 64'(dx1) * 64'(ply1);
    pn1  <= 66'(dy1) * 66'(sx1);
    pn2  <= 66'(dx1) * 66'(sy1);
    py1  <= 66'(plx1) * 66'(sy1);
    py2  <= 66'(ply1) * 66'(sx1);

    tag3 <= tag2;
    det3 <= 65'(pd1) - 65'(pd2);
    nx3  <= 67'(pn1) - 67'(pn2);
    ny3  <= 67'(py1) - 67'(py2);

    tag4     <= tag3;
    numc4    <= 80'(sum3) * $signed(80'(half_w));
    nums4    <= 78'(det3) * $signed(78'(scr_h));
    ny4      <= ny3;
    det_zero4 <= (det3 == '0);
    ny_zero4  <= (ny3 == '0);
  end

  assign sum3   = 68'(ny3) + 68'(nx3);
  assign numc_x = 84'(numc4);
  assign nums_x = 84'(nums4);
  assign ny_x   = 84'(ny4);

  // stage 5: magnitudes and status
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    dout.tag   <= tag4;
    dout.status <= det_zero4 ? ssp_pkg::STATUS_SINGULAR :
                   ny_zero4  ? ssp_pkg::STATUS_NO_DEPTH : ssp_pkg::STATUS_OK;
    dout.neg_c <= numc4[79] ^ ny4[66];
    dout.rem_c <= numc4[79] ? $unsigned(-numc_x) : $unsigned(numc_x);
    dout.rem_s <= nums4[77] ? $unsigned(-nums_x) : $unsigned(nums_x);
    dout.dv    <= ny4[66] ? $unsigned(-ny_x) : $unsigned(ny_x);
    dout.qc    <= '0;
    dout.qs    <= '0;
  end

endmodule

// File: hw/rtl/ssp_div_step.sv
// ----------------------------------------------------------------------------
// ssp_div_step
// One restoring division step for the column quotient and, when EN_S is set, the size quotient.
// ----------------------------------------------------------------------------
module ssp_div_step #(
  parameter int SHIFT_C = 0,
  parameter int SHIFT_S = 0,
  parameter bit EN_S    = 1'b1
) (
  input  logic              clk,
  input  logic              rst,
  input  ssp_pkg::ssp_div_t din,
  output ssp_pkg::ssp_div_t dout
);

  logic [ssp_pkg::RemW:0] trial_c, trial_s;

  assign trial_c = {1'b0, din.rem_c} - {1'b0, din.dv << SHIFT_C};
  assign trial_s = {1'b0, din.rem_s} - {1'b0, din.dv << SHIFT_S};

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    dout.tag    <= din.tag;
    dout.status <= din.status;
    dout.neg_c  <= din.neg_c;
    dout.dv     <= din.dv;
    // take the bit when no borrow
    if (!trial_c[ssp_pkg::RemW]) begin
      dout.rem_c <= trial_c[ssp_pkg::RemW-1:0];
      dout.qc    <= din.qc | (ssp_pkg::QcW'(1) << SHIFT_C);
    end else begin
      dout.rem_c <= din.rem_c;
      dout.qc    <= din.qc;
    end
    if (EN_S && !trial_s[ssp_pkg::RemW]) begin
      dout.rem_s <= trial_s[ssp_pkg::RemW-1:0];
      dout.qs    <= din.qs | (ssp_pkg::QsW'(1) << SHIFT_S);
    end else begin
      dout.rem_s <= din.rem_s;
      dout.qs    <= din.qs;
    end
  end

endmodule

// File: hw/rtl/ssp_back.sv
// ----------------------------------------------------------------------------
// ssp_back
// Saturates the quotients, then forms the clamped draw bounds. Two stages.
// ----------------------------------------------------------------------------
module ssp_back (
  input  logic              clk,
  input  logic              rst,
  input  ssp_pkg::ssp_div_t din,
  input  logic [12:0]       scr_w,
  input  logic [12:0]       scr_h,
  output logic              done,
  output logic [7:0]        sprite_tag,
  output logic signed [15:0] screen_column,
  output logic [14:0]       sprite_size,
  output logic [11:0]       row_start,
  output logic [11:0]       row_end,
  output logic [14:0]       column_first,
  output logic signed [15:0] column_last,
  output logic signed [15:0] column_before,
  output logic [1:0]        status
);

  logic               vld1;
  logic [7:0]         tag1;
  ssp_pkg::status_t   st1;
  logic signed [15:0] col1, col_next;
  logic [14:0]        size1, size_next;

  logic [13:0]        half_s;
  logic [11:0]        half_h;
  logic signed [17:0] rs, cf, cl;
  logic [14:0]        re;
  logic [11:0]        rs_c, re_c;
  logic [14:0]        cf_c;
  logic signed [15:0] cl_c;
  logic               ok;

  always_comb begin
    if (din.neg_c) begin
      if (din.qc > 17'd32768) col_next = 16'sh8000;
      else col_next = 16'(-$signed({1'b0, din.qc}));
    end else begin
      if (din.qc > 17'd32767) col_next = 16'sh7FFF;
      else col_next = din.qc[15:0];
    end
    size_next = din.qs[15] ? 15'h7FFF : din.qs[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      done <= 1'b0;
    end else begin
      vld1 <= din.valid;
      done <= vld1;
    end
  end

  always_comb begin
    half_s = size1[14:1];
    half_h = scr_h[12:1];
    rs = $signed(18'(half_h)) - $signed(18'(half_s));
    re = 15'(half_s) + 15'(half_h);
    cf = 18'(col1) - $signed(18'(half_s));
    cl = 18'(col1) + $signed(18'(half_s));
    rs_c = rs[17] ? 12'd0 : rs[11:0];
    re_c = (re >= 15'(scr_h)) ? 12'(scr_h - 13'd1) : re[11:0];
    cf_c = cf[17] ? 15'd0 : cf[14:0];
    cl_c = (cl >= $signed(18'(scr_w))) ? 16'(scr_w - 13'd1) : cl[15:0];
    ok   = (st1 == ssp_pkg::STATUS_OK);
  end

  always_ff @(posedge clk) begin
    tag1  <= din.tag;
    st1   <= din.status;
    col1  <= col_next;
    size1 <= size_next;

    sprite_tag    <= tag1;
    status        <= st1;
    screen_column <= ok ? col1 : '0;
    sprite_size   <= ok ? size1 : '0;
    row_start     <= ok ? rs_c : '0;
    row_end       <= ok ? re_c : '0;
    column_first  <= ok ? cf_c : '0;
    column_last   <= ok ? cl_c : '0;
    column_before <= ok ? 16'(cf_c) - 16'sd1 : '0;
  end

endmodule

// File: hw/rtl/sprite_screen_projection_top.sv
// ----------------------------------------------------------------------------
// sprite_screen_projection_top
// Projects one sprite into screen column, size and clamped draw bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a sprite and the camera pose on the input ports; the
//   request is taken at any edge where start is high and busy is low. busy
//   is high only while rst is high, so one request enters every cycle.
//   Each request gives one result, shown for one cycle with done high. A
//   request passes five front stages (offset, products, differences,
//   scaling, magnitudes), seventeen one-bit divider stages and two output
//   stages; throughput is one per cycle. The receiver cannot stall, so
//   the pipeline never holds.
//   screen_width and screen_height are written through cfg_valid /
//   cfg_ready (always ready) with cfg_index and cfg_data; change them only
//   while no request is in flight. Values are clamped to 1..4096 in use.
//   Reset empties the pipeline and restores 640 by 480.
//   status is 1 for a singular camera matrix and 2 for zero depth; all
//   other fields but sprite_tag are then zero.
// ----------------------------------------------------------------------------
module sprite_screen_projection_top #(
  parameter int FRAC_BITS = ssp_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         sprite_index,
  input  logic signed [31:0] sprite_x,
  input  logic signed [31:0] sprite_y,
  input  logic signed [31:0] player_x,
  input  logic signed [31:0] player_y,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] plane_x,
  input  logic signed [31:0] plane_y,
  output logic               done,
  output logic [7:0]         sprite_tag,
  output logic signed [15:0] screen_column,
  output logic [14:0]        sprite_size,
  output logic [11:0]        row_start,
  output logic [11:0]        row_end,
  output logic [14:0]        column_first,
  output logic signed [15:0] column_last,
  output logic signed [15:0] column_before,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  localparam int Latency = 5 + ssp_pkg::DivSteps + 2;

  logic [12:0] screen_width, screen_height;
  logic [12:0] w_use, h_use;
  ssp_pkg::ssp_div_t chain [ssp_pkg::DivSteps+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ssp_pkg::WidthReset;
      screen_height <= ssp_pkg::HeightReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ssp_pkg::REG_SCREEN_WIDTH) screen_width <= cfg_data;
      else if (cfg_index == ssp_pkg::REG_SCREEN_HEIGHT) screen_height <= cfg_data;
    end
  end

  assign w_use = (screen_width < ssp_pkg::DimMin) ? ssp_pkg::DimMin :
                 (screen_width > ssp_pkg::DimMax) ? ssp_pkg::DimMax : screen_width;
  assign h_use = (screen_height < ssp_pkg::DimMin) ? ssp_pkg::DimMin :
                 (screen_height > ssp_pkg::DimMax) ? ssp_pkg::DimMax : screen_height;

  ssp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .in_tag(sprite_index),
    .sprite_x(sprite_x), .sprite_y(sprite_y), .player_x(player_x),
    .player_y(player_y), .dir_x(dir_x), .dir_y(dir_y), .plane_x(plane_x),
    .plane_y(plane_y), .half_w(w_use[12:1]), .scr_h(h_use), .dout(chain[0])
  );

  for (genvar k = 0; k < ssp_pkg::DivSteps; k++) begin : g_div
    ssp_div_step #(
      .SHIFT_C(ssp_pkg::DivSteps - 1 - k),
      .SHIFT_S((k < ssp_pkg::DivSteps - 1) ? ssp_pkg::DivSteps - 2 - k : 0),
      .EN_S(k < ssp_pkg::DivSteps - 1)
    ) u_step (
      .clk(clk), .rst(rst), .din(chain[k]), .dout(chain[k+1])
    );
  end

  ssp_back u_back (
    .clk(clk), .rst(rst), .din(chain[ssp_pkg::DivSteps]), .scr_w(w_use),
    .scr_h(h_use), .done(done), .sprite_tag(sprite_tag),
    .screen_column(screen_column), .sprite_size(sprite_size),
    .row_start(row_start), .row_end(row_end), .column_first(column_first),
    .column_last(column_last), .column_before(column_before), .status(status)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, Latency))
    else $error("result strobe does not match request latency");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != ssp_pkg::STATUS_OK) |-> (screen_column == 16'sd0) &&
      (sprite_size == 15'd0) && (column_before == 16'sd0))
    else $error("fault result carries nonzero fields");

  a_rows_ordered: assert property (@(posedge clk) disable iff (rst)
    done && (status == ssp_pkg::STATUS_OK) |-> row_start <= row_end)
    else $error("row bounds out of order");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    done && (status == ssp_pkg::STATUS_OK) |->
      column_before == 16'(column_first) - 16'sd1)
    else $error("stripe cursor mismatch");

endmodule

// File: tb/sv/tb_sprite_screen_projection_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sprite_screen_projection_top
// Sends sprites and camera poses through the projection pipeline and checks
// every result against an exact 128-bit projection predictor. The run steps
// through several window sizes, the clamped extremes included.
// ----------------------------------------------------------------------------
module tb_sprite_screen_projection_top;

  localparam int Latency = 24;
  localparam int SettleCycles = Latency + 6;
  localparam int StallLimit = 5000;
  localparam int ItemsPerPhase = 140;
  localparam logic [7:0] RegUnused = 8'd7;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [7:0]         index;
    logic signed [31:0] spr_x, spr_y, ply_x, ply_y, dx, dy, plx, ply;
  } sprite_req_t;

  typedef struct {
    logic [7:0]         tag;
    logic signed [15:0] column;
    logic [14:0]        size;
    logic [11:0]        rs, re;
    logic [14:0]        cf;
    logic signed [15:0] cl, cb;
    logic [1:0]         st;
  } projection_t;

  class proj_scoreboard;
    projection_t expected_q[$];
    int width_reg = 640;
    int height_reg = 480;
    int errors = 0;

    function void write_reg(logic [7:0] idx, logic [12:0] data);
      if (idx == ssp_pkg::REG_SCREEN_WIDTH) width_reg = data;
      else if (idx == ssp_pkg::REG_SCREEN_HEIGHT) height_reg = data;
    endfunction

    function int clamp_dim(int v);
      if (v < 1) return 1;
      if (v > 4096) return 4096;
      return v;
    endfunction

    function projection_t project(sprite_req_t r);
      projection_t p;
      wide_t sx, sy, det, nx, ny, q, half;
      int w, h, col, sz, rs, re, cf, cl;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      half = 128'sd32768;
      p = '{default: '0};
      p.tag = r.index;
      sx = wide_t'(r.spr_x) - wide_t'(r.ply_x) + half;
      sy = wide_t'(r.spr_y) - wide_t'(r.ply_y) + half;
      det = wide_t'(r.plx) * wide_t'(r.dy) - wide_t'(r.dx) * wide_t'(r.ply);
      nx = wide_t'(r.dy) * sx - wide_t'(r.dx) * sy;
      ny = wide_t'(r.plx) * sy - wide_t'(r.ply) * sx;
      if (det == 0) begin
        p.st = ssp_pkg::STATUS_SINGULAR;
        return p;
      end
      if (ny == 0) begin
        p.st = ssp_pkg::STATUS_NO_DEPTH;
        return p;
      end
      q = ((ny + nx) * wide_t'(w / 2)) / ny;
      if (q > 32767) col = 32767;
      else if (q < -32768) col = -32768;
      else col = int'(q);
      q = (det * wide_t'(h)) / ny;
      if (q < 0) q = -q;
      sz = (q > 32767) ? 32767 : int'(q);
      rs = h / 2 - sz / 2;
      if (rs < 0) rs = 0;
      re = sz / 2 + h / 2;
      if (re >= h) re = h - 1;
      cf = col - sz / 2;
      if (cf < 0) cf = 0;
      cl = sz / 2 + col;
      if (cl >= w) cl = w - 1;
      p.column = col[15:0];
      p.size = sz[14:0];
      p.rs = rs[11:0];
      p.re = re[11:0];
      p.cf = cf[14:0];
      p.cl = cl[15:0];
      p.cb = 16'(cf - 1);
      p.st = ssp_pkg::STATUS_OK;
      return p;
    endfunction

    function void note(sprite_req_t r);
      expected_q.push_back(project(r));
    endfunction

    task report(string field, int got, int want);
      $display("[%0t] %s: got %0d expected %0d", $realtime, field, got, want);
      errors++;
    endtask

    task check(projection_t got);
      projection_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, tag", got.tag, -1);
        return;
      end
      e = expected_q.pop_front();
      if (got.tag !== e.tag) report("sprite_tag", got.tag, e.tag);
      if (got.column !== e.column) report("screen_column", got.column, e.column);
      if (got.size !== e.size) report("sprite_size", got.size, e.size);
      if (got.rs !== e.rs) report("row_start", got.rs, e.rs);
      if (got.re !== e.re) report("row_end", got.re, e.re);
      if (got.cf !== e.cf) report("column_first", got.cf, e.cf);
      if (got.cl !== e.cl) report("column_last", got.cl, e.cl);
      if (got.cb !== e.cb) report("column_before", got.cb, e.cb);
      if (got.st !== e.st) report("status", got.st, e.st);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, cfg_ready;
  logic [7:0] sprite_index = '0;
  logic signed [31:0] sprite_x = '0, sprite_y = '0, player_x = '0, player_y = '0;
  logic signed [31:0] dir_x = '0, dir_y = '0, plane_x = '0, plane_y = '0;
  logic [7:0] sprite_tag;
  logic signed [15:0] screen_column, column_last, column_before;
  logic [14:0] sprite_size, column_first;
  logic [11:0] row_start, row_end;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;

  proj_scoreboard sb = new();
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  sprite_screen_projection_top DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both sides at the edge, compare results before noting requests.
  always @(posedge clk) begin
    bit moved;
    sprite_req_t r;
    projection_t got;
    moved = 1'b0;
    if (!rst) begin
      if (done) begin
        got = '{sprite_tag, screen_column, sprite_size, row_start, row_end,
                column_first, column_last, column_before, status};
        sb.check(got);
        moved = 1'b1;
      end
      if (start && !busy) begin
        r = '{sprite_index, sprite_x, sprite_y, player_x, player_y,
              dir_x, dir_y, plane_x, plane_y};
        sb.note(r);
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_sprite(sprite_req_t r);
    idle_burst();
    start <= 1'b1;
    sprite_index <= r.index;
    sprite_x <= r.spr_x;
    sprite_y <= r.spr_y;
    player_x <= r.ply_x;
    player_y <= r.ply_y;
    dir_x <= r.dx;
    dir_y <= r.dy;
    plane_x <= r.plx;
    plane_y <= r.ply;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic sprite_req_t pose(logic signed [31:0] sxv, syv, pxv, pyv,
                                      dxv, dyv, plxv, plyv);
    sprite_req_t r;
    r = '{8'($urandom_range(0, 255)), sxv, syv, pxv, pyv, dxv, dyv, plxv, plyv};
    return r;
  endfunction

  function automatic logic signed [31:0] near(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly a sane camera with sprites near the player, some pure noise.
  function automatic sprite_req_t random_sprite();
    sprite_req_t r;
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      r = pose($urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    end else if (k < 3) begin
      r = pose(near(1 << 20), near(1 << 20), near(1 << 20), near(1 << 20),
               near(300), near(300), near(300), near(300));
    end else begin
      r = pose(near(40 << 16), near(40 << 16), near(40 << 16), near(40 << 16),
               near(1 << 17), near(1 << 17), near(1 << 17), near(1 << 17));
    end
    r.index = 8'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic directed_sprites();
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    one = 32'sh00010000;
    // singular camera: zero direction and plane
    send_sprite(pose(one, one, 0, 0, 0, 0, 0, 0));
    // singular camera: parallel direction and plane
    send_sprite(pose(one, 0, 0, 0, one, one, one, one));
    // zero depth: sprite lands on the player after the half offset
    send_sprite(pose(-32768, -32768, 0, 0, -one, 0, 0, 43253));
    send_sprite(pose(mx, mx, mn, mn, mx, mn, mx, mx));
    send_sprite(pose(mn, mn, mx, mx, mn, mx, mn, mn));
    send_sprite(pose(mx, mn, mx, mn, mn, mn, mx, mn));
    send_sprite(pose(mn, mx, mn, mx, mx, mx, mn, mx));
    send_sprite(pose(-1, -1, -1, -1, -1, -1, -1, -1));
    send_sprite(pose(5 * one, 3 * one, 2 * one, 2 * one, -one, 0, 0, 43253));
    send_sprite(pose(2 * one, 9 * one, 2 * one, 2 * one, 0, one, 43253, 0));
    send_sprite(pose(one, 2 * one, one, one, one, 0, 0, -one));
    // tiny depth: size saturates
    send_sprite(pose(-32767, -32768, 0, 0, -one, 0, 0, one));
    send_sprite(pose(-32768, -32767, 0, 0, 0, one, one, 0));
    send_sprite(pose(100 * one, 0, 0, 0, one, 0, 0, one));
    send_sprite(pose(0, 0, 100 * one, 100 * one, one, one, -one, one));
    send_sprite(pose(3 * one, one, 0, 0, one, 0, 0, 1));
    send_sprite(pose(3 * one, one, 0, 0, 1, 0, 0, mx));
    send_sprite('{8'hff, 0, 0, 0, 0, one, 0, 0, one});
  endtask

  initial begin
    int widths[6];
    int heights[6];
    int n;
    widths = '{640, 1, 4096, 0, 8191, 0};
    heights = '{480, 1, 4096, 8191, 0, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_sprites();
    drain();
    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) begin
        if (ph == 5) begin
          widths[5] = $urandom_range(2, 800);
          heights[5] = $urandom_range(2, 600);
        end
        write_reg(ssp_pkg::REG_SCREEN_WIDTH, 13'(widths[ph]));
        write_reg(ssp_pkg::REG_SCREEN_HEIGHT, 13'(heights[ph]));
      end else begin
        write_reg(RegUnused, 13'd3);
        write_reg(ssp_pkg::REG_SCREEN_WIDTH, 13'd320);
        write_reg(ssp_pkg::REG_SCREEN_HEIGHT, 13'd200);
      end
      n = (ph == 0) ? 10 : ItemsPerPhase;
      for (int i = 0; i < n; i++) begin
        if (ph == 6 && i == 20) idle_on = 1'b0;
        if (ph == 2 && i == 50) begin
          // hold requests until the pipeline is empty
          start <= 1'b0;
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send_sprite(random_sprite());
      end
      drain();
    end
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
